[hdl/lcdw_pkg.sv]
// Shared types, constants and command/status structs for the character LCD nibble writer.
package lcdw_pkg;

    localparam int LineChars = 16;
    localparam int CntW      = 5;
    localparam int InitLen   = 8;
    localparam int IdxW      = $clog2(InitLen);

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] LINE_CMD_A   = 8'hA8;
    localparam logic [7:0] LINE_CMD_B   = 8'h80;

    localparam logic [7:0] INIT_CMDS [InitLen] = '{
        8'h33, 8'h32, 8'h28, 8'h08, 8'h04, 8'h01, 8'h02, 8'h0E
    };

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_CMD  = 2'd1,
        OP_INIT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAR,
        S_PAD,
        S_LINE,
        S_RAW,
        S_INIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_BYTE,
        SRC_SPACE,
        SRC_LINE,
        SRC_INIT
    } src_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic emit;
        src_t src;
        logic rs;
        logic last;
        logic cnt_inc;
        logic line_done;
        logic idx_inc;
    } cmd_t;

    typedef struct packed {
        logic newline;
        logic out_free;
        logic half_lo;
        logic cnt_end;
        logic idx_end;
    } sts_t;

endpackage

[hdl/lcdw_if.sv]
// Valid/ready channel interfaces for request words and bus transfer words.
interface lcdw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface lcdw_xfer_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;

    modport source (output valid, output reg_select, output nibble, output last, input ready);
    modport sink (input valid, input reg_select, input nibble, input last, output ready);
endinterface

[hdl/lcdw_dp.sv]
// Datapath: held byte, line counters, init index, nibble select and output register.
module lcdw_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_code,
    input  lcdw_pkg::cmd_t      cmd,
    output lcdw_pkg::sts_t      sts,
    lcdw_xfer_if.source         xfer
);

    logic [7:0]                 byte_reg;
    logic [7:0]                 byte_next;
    logic [lcdw_pkg::CntW-1:0]  count_reg;
    logic [lcdw_pkg::CntW-1:0]  count_next;
    logic                       first_reg;
    logic                       first_next;
    logic                       half_reg;
    logic                       half_next;
    logic [lcdw_pkg::IdxW-1:0]  idx_reg;
    logic [lcdw_pkg::IdxW-1:0]  idx_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_rs_reg;
    logic [3:0]                 out_nibble_reg;
    logic                       out_last_reg;
    logic [7:0]                 tx_byte;

    always_comb
    begin
        unique case (cmd.src)
            lcdw_pkg::SRC_BYTE:  tx_byte = byte_reg;
            lcdw_pkg::SRC_SPACE: tx_byte = lcdw_pkg::SPACE_CHAR;
            lcdw_pkg::SRC_LINE:  tx_byte = first_reg ? lcdw_pkg::LINE_CMD_A
                                                     : lcdw_pkg::LINE_CMD_B;
            lcdw_pkg::SRC_INIT:  tx_byte = lcdw_pkg::INIT_CMDS[idx_reg];
            default:             tx_byte = byte_reg;
        endcase
    end

    always_comb
    begin
        byte_next      = cmd.load ? char_code : byte_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        idx_next       = idx_reg;
        half_next      = cmd.emit ? ~half_reg : half_reg;
        out_valid_next = out_valid_reg;
        if (cmd.restart)
        begin
            count_next = '0;
            first_next = 1'b1;
            idx_next   = '0;
        end
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.line_done)
        begin
            count_next = '0;
            first_next = ~first_reg;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (xfer.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_reg     <= 1'b1;
            half_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            first_reg     <= first_next;
            half_reg      <= half_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (cmd.emit)
        begin
            out_rs_reg     <= cmd.rs;
            out_nibble_reg <= half_reg ? tx_byte[3:0] : tx_byte[7:4];
            out_last_reg   <= cmd.last;
        end
    end

    assign sts.newline  = (char_code == lcdw_pkg::NEWLINE_CHAR);
    assign sts.out_free = ~out_valid_reg | xfer.ready;
    assign sts.half_lo  = half_reg;
    assign sts.cnt_end  = (count_reg == lcdw_pkg::CntW'(lcdw_pkg::LineChars - 1));
    assign sts.idx_end  = (idx_reg == lcdw_pkg::IdxW'(lcdw_pkg::InitLen - 1));

    assign xfer.valid      = out_valid_reg;
    assign xfer.reg_select = out_rs_reg;
    assign xfer.nibble     = out_nibble_reg;
    assign xfer.last       = out_last_reg;

`ifndef SYNTHESIS
    a_count_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lcdw_pkg::CntW'(lcdw_pkg::LineChars - 1))
        else $error("line count past end of line");
    a_last_on_low: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |-> half_reg)
        else $error("final word is not a low nibble");
`endif

endmodule

[hdl/lcdw_ctrl.sv]
// Controller: sequences character, padding, line, raw and init transfers.
module lcdw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [1:0]      req_opcode,
    output logic            req_ready,
    input  lcdw_pkg::sts_t  sts,
    output lcdw_pkg::cmd_t  cmd
);

    lcdw_pkg::state_t state_reg;
    lcdw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcdw_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = lcdw_pkg::SRC_BYTE;
        req_ready  = (state_reg == lcdw_pkg::S_IDLE);
        unique case (state_reg) inside
            lcdw_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (lcdw_pkg::op_t'(req_opcode))
                        lcdw_pkg::OP_CHAR:
                            state_next = sts.newline ? lcdw_pkg::S_PAD : lcdw_pkg::S_CHAR;
                        lcdw_pkg::OP_CMD:
                            state_next = lcdw_pkg::S_RAW;
                        lcdw_pkg::OP_INIT:
                        begin
                            cmd.restart = 1'b1;
                            state_next  = lcdw_pkg::S_INIT;
                        end
                        lcdw_pkg::OP_NONE:
                            state_next = lcdw_pkg::S_IDLE;
                        default:
                            state_next = lcdw_pkg::S_IDLE;
                    endcase
                end
            end
            lcdw_pkg::S_CHAR, lcdw_pkg::S_PAD:
            begin
                cmd.rs  = 1'b1;
                cmd.src = (state_reg == lcdw_pkg::S_PAD) ? lcdw_pkg::SRC_SPACE
                                                         : lcdw_pkg::SRC_BYTE;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.half_lo)
                    begin
                        if (sts.cnt_end)
                        begin
                            state_next = lcdw_pkg::S_LINE;
                        end
                        else
                        begin
                            cmd.cnt_inc = 1'b1;
                            if (state_reg == lcdw_pkg::S_CHAR)
                            begin
                                cmd.last   = 1'b1;
                                state_next = lcdw_pkg::S_IDLE;
                            end
                        end
                    end
                end
            end
            lcdw_pkg::S_LINE:
            begin
                cmd.src = lcdw_pkg::SRC_LINE;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.half_lo)
                    begin
                        cmd.last      = 1'b1;
                        cmd.line_done = 1'b1;
                        state_next    = lcdw_pkg::S_IDLE;
                    end
                end
            end
            lcdw_pkg::S_RAW:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.half_lo)
                    begin
                        cmd.last   = 1'b1;
                        state_next = lcdw_pkg::S_IDLE;
                    end
                end
            end
            lcdw_pkg::S_INIT:
            begin
                cmd.src = lcdw_pkg::SRC_INIT;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.half_lo)
                    begin
                        cmd.idx_inc = 1'b1;
                        if (sts.idx_end)
                        begin
                            cmd.last   = 1'b1;
                            state_next = lcdw_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = lcdw_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lcdw_pkg::S_IDLE |-> !cmd.emit)
        else $error("transfer issued while idle");
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != lcdw_pkg::S_IDLE && state_next == lcdw_pkg::S_IDLE
        |-> cmd.emit && cmd.last)
        else $error("request finished without a final word");
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("transfer issued into a full output register");
`endif

endmodule

[hdl/char_lcd_nibble_writer_top.sv]
// Top level of the character LCD nibble writer: controller plus datapath.
//
// Usage: requests arrive on req (opcode, char_code); bus transfer words leave on
// xfer (reg_select, nibble, last), one word per cycle at most. Every byte goes
// out as two words, high nibble first; last marks the final word of a request.
// Opcode 0 writes a character (newline pads the line with spaces), opcode 1
// sends a raw command byte, opcode 2 clears the line state and sends the
// eight-command init sequence, opcode 3 is taken and dropped.
// A request is taken only while the controller is idle. After acceptance the
// controller state leaves idle and then the output register loads the first
// word, once the output register has room. The single output register loads
// one word per cycle while the receiver keeps taking them, and the controller
// handles one request at a time, so a new request waits until the final word
// of the previous one is loaded into the output register.
// When the receiver stalls, the output word holds and the sequence pauses.
// Reset clears the line count, selects the first line address and empties
// the output register.
module char_lcd_nibble_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    lcdw_req_if.sink    req,
    lcdw_xfer_if.source xfer
);

    lcdw_pkg::cmd_t cmd;
    lcdw_pkg::sts_t sts;

    lcdw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    lcdw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (req.char_code),
        .cmd       (cmd),
        .sts       (sts),
        .xfer      (xfer)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the character LCD nibble writer: directed and random requests in, bus words checked.
module testbench;
    import lcdw_pkg::*;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } lcd_word_t;

    typedef struct {
        op_t        op;
        logic [7:0] code;
        bit         hold_idle;
    } lcd_req_t;

    logic clk;
    logic rst_n;

    lcdw_req_if  req ();
    lcdw_xfer_if xfer ();

    char_lcd_nibble_writer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .xfer  (xfer)
    );

    lcd_req_t  req_queue [$];
    lcd_word_t lcd_words [$];
    lcd_word_t staged [64];
    int        n_staged;

    logic [4:0] line_count;
    logic       first_line;

    logic     req_taken;
    logic     word_taken;
    int       req_gap;
    int       ready_stall;
    bit       req_burst;
    bit       ready_burst;
    lcd_req_t head_req;
    lcd_word_t want;

    int errors;
    int words_checked;
    int n_chars;
    int n_newlines;
    int n_cmds;
    int n_inits;
    int n_dropped;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic stage_byte(input logic rs, input logic [7:0] b);
        staged[n_staged]     = '{rs: rs, nib: b[7:4], last: 1'b0};
        staged[n_staged + 1] = '{rs: rs, nib: b[3:0], last: 1'b0};
        n_staged += 2;
    endtask

    task automatic stage_line_cmd();
        stage_byte(1'b0, first_line ? LINE_CMD_A : LINE_CMD_B);
        line_count = '0;
        first_line = ~first_line;
    endtask

    task automatic predict_transfers(input op_t op, input logic [7:0] code);
        n_staged = 0;
        case (op)
            OP_CHAR:
            begin
                if (code != NEWLINE_CHAR)
                begin
                    n_chars++;
                    line_count = line_count + 5'd1;
                    stage_byte(1'b1, code);
                    if (line_count >= LineChars)
                        stage_line_cmd();
                end
                else
                begin
                    n_newlines++;
                    while (line_count < LineChars)
                    begin
                        stage_byte(1'b1, SPACE_CHAR);
                        line_count = line_count + 5'd1;
                    end
                    stage_line_cmd();
                end
            end
            OP_CMD:
            begin
                n_cmds++;
                stage_byte(1'b0, code);
            end
            OP_INIT:
            begin
                n_inits++;
                line_count = '0;
                first_line = 1'b1;
                for (int i = 0; i < InitLen; i++)
                    stage_byte(1'b0, INIT_CMDS[i]);
            end
            default:
                n_dropped++;
        endcase
        if (n_staged > 0)
            staged[n_staged - 1].last = 1'b1;
        for (int i = 0; i < n_staged; i++)
            lcd_words.push_back(staged[i]);
    endtask

    task automatic queue_req(input op_t op, input logic [7:0] code);
        req_queue.push_back('{op: op, code: code, hold_idle: 1'b0});
    endtask

    task automatic queue_pause();
        req_queue.push_back('{op: OP_NONE, code: 8'h00, hold_idle: 1'b1});
    endtask

    // present the next request word, with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req_gap = 0;
        end
        else if (!req.valid || req_taken)
        begin
            if (req_gap > 0)
            begin
                req.valid <= 1'b0;
                req_gap--;
            end
            else if (req_queue.size() > 0 && req_queue[0].hold_idle)
            begin
                req.valid <= 1'b0;
                if (lcd_words.size() == 0)
                    void'(req_queue.pop_front());
            end
            else if (req_queue.size() > 0)
            begin
                head_req = req_queue.pop_front();
                req.valid     <= 1'b1;
                req.opcode    <= head_req.op;
                req.char_code <= head_req.code;
                if ($urandom_range(0, 15) == 0)
                    req_burst = ~req_burst;
                req_gap = req_burst ? 0 : $urandom_range(0, 3);
            end
            else
                req.valid <= 1'b0;
        end
    end

    // stall the bus side at random
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            xfer.ready <= 1'b0;
            ready_stall = 0;
        end
        else if (word_taken || !xfer.ready)
        begin
            if (word_taken)
            begin
                if ($urandom_range(0, 15) == 0)
                    ready_burst = ~ready_burst;
                ready_stall = ready_burst ? 0 : $urandom_range(0, 3);
            end
            if (ready_stall > 0)
            begin
                xfer.ready <= 1'b0;
                ready_stall--;
            end
            else
                xfer.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken  <= 1'b0;
            word_taken <= 1'b0;
        end
        else
        begin
            req_taken  <= req.valid && req.ready;
            word_taken <= xfer.valid && xfer.ready;
            if (xfer.valid && xfer.ready)
            begin
                words_checked++;
                if (lcd_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got rs=%0b nibble=%h last=%0b",
                             $time, xfer.reg_select, xfer.nibble, xfer.last);
                end
                else
                begin
                    want = lcd_words.pop_front();
                    if (xfer.reg_select !== want.rs)
                    begin
                        errors++;
                        $display("%0t: reg_select expected %0b got %0b",
                                 $time, want.rs, xfer.reg_select);
                    end
                    if (xfer.nibble !== want.nib)
                    begin
                        errors++;
                        $display("%0t: nibble expected %h got %h", $time, want.nib, xfer.nibble);
                    end
                    if (xfer.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: last expected %0b got %0b", $time, want.last, xfer.last);
                    end
                end
            end
            if (req.valid && req.ready)
                predict_transfers(op_t'(req.opcode), req.char_code);
        end
    end

    initial
    begin
        int   counted;
        int   pick;
        op_t  op;
        logic [7:0] code;

        req.valid     = 1'b0;
        req.opcode    = OP_CHAR;
        req.char_code = 8'h00;
        xfer.ready    = 1'b0;
        rst_n         = 1'b0;
        line_count    = '0;
        first_line    = 1'b1;
        req_burst     = 1'b0;
        ready_burst   = 1'b0;
        errors        = 0;
        words_checked = 0;
        n_chars       = 0;
        n_newlines    = 0;
        n_cmds        = 0;
        n_inits       = 0;
        n_dropped     = 0;

        queue_req(OP_INIT, 8'hC3);
        queue_req(OP_CHAR, 8'h41);
        queue_req(OP_CHAR, NEWLINE_CHAR);
        queue_req(OP_CHAR, NEWLINE_CHAR);
        queue_req(OP_CMD, 8'h00);
        queue_req(OP_CMD, 8'hFF);
        queue_req(OP_NONE, 8'h5A);
        queue_req(OP_CHAR, 8'h00);
        queue_req(OP_CHAR, 8'hFF);
        for (int i = 0; i < 14; i++)
            queue_req(OP_CHAR, 8'h30 + i[7:0]);
        queue_pause();
        queue_req(OP_CHAR, 8'h7E);
        queue_req(OP_INIT, 8'h3C);

        counted = 0;
        while (counted < 100)
        begin
            pick = $urandom_range(0, 99);
            code = 8'($urandom_range(0, 255));
            if (pick < 5)
                op = OP_NONE;
            else if (pick < 10)
                op = OP_INIT;
            else if (pick < 25)
                op = OP_CMD;
            else
            begin
                op = OP_CHAR;
                if ($urandom_range(0, 7) == 0)
                    code = NEWLINE_CHAR;
            end
            queue_req(op, code);
            if (op != OP_NONE)
                counted++;
            if (counted == 50 && op != OP_NONE)
                queue_pause();
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_queue.size() > 0 || req.valid)
            @(posedge clk);
        while (lcd_words.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d characters, %0d newlines, %0d commands, %0d inits, %0d dropped.",
                 n_chars, n_newlines, n_cmds, n_inits, n_dropped);
        $display("Checked %0d bus words under random gaps and stalls.", words_checked);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d words still expected.", lcd_words.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
hdl/lcdw_pkg.sv
hdl/lcdw_if.sv
hdl/lcdw_dp.sv
hdl/lcdw_ctrl.sv
hdl/char_lcd_nibble_writer_top.sv
tb/testbench.sv
